[rtl/core/scrf_pkg.sv]
// ----------------------------------------------------------------------------
// scrf_pkg
// Word map, reset values, status codes and decode types shared by the
// system control register file.
// ----------------------------------------------------------------------------
`default_nettype none

package scrf_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [IDX_W-1:0] W_KEY      = 10'h000;
  localparam logic [IDX_W-1:0] W_REV1     = 10'h001;
  localparam logic [IDX_W-1:0] W_REV2     = 10'h005;
  localparam logic [IDX_W-1:0] W_RST1     = 10'h010;
  localparam logic [IDX_W-1:0] W_RST2     = 10'h014;
  localparam logic [IDX_W-1:0] W_CLK1     = 10'h020;
  localparam logic [IDX_W-1:0] W_CLK2     = 10'h024;
  localparam logic [IDX_W-1:0] W_HPLL     = 10'h080;
  localparam logic [IDX_W-1:0] W_HPLL_EXT = 10'h081;
  localparam logic [IDX_W-1:0] W_MPLL_EXT = 10'h089;
  localparam logic [IDX_W-1:0] W_EPLL_EXT = 10'h091;
  localparam logic [IDX_W-1:0] W_STRAP1   = 10'h140;
  localparam logic [IDX_W-1:0] W_STRAP2   = 10'h144;
  localparam logic [IDX_W-1:0] W_PROT1    = 10'h142;
  localparam logic [IDX_W-1:0] W_PROT2    = 10'h146;
  localparam logic [IDX_W-1:0] W_RNG      = 10'h150;
  localparam logic [IDX_W-1:0] W_ID0      = 10'h16C;
  localparam logic [IDX_W-1:0] W_ID1      = 10'h16D;

  localparam logic [DATA_W-1:0] RST1_INIT = 32'hF7C3_FED8;
  localparam logic [DATA_W-1:0] RST2_INIT = 32'hFFFF_FFFC;
  localparam logic [DATA_W-1:0] CLK1_INIT = 32'hFFFF_7F8A;
  localparam logic [DATA_W-1:0] CLK2_INIT = 32'hFFF0_FFF0;
  localparam logic [DATA_W-1:0] HPLL_INIT = 32'h1000_405F;
  localparam logic [DATA_W-1:0] ID0_VALUE = 32'h1234_ABCD;
  localparam logic [DATA_W-1:0] ID1_VALUE = 32'h8888_4444;
  localparam logic [DATA_W-1:0] PLL_LOCK  = 32'h8000_0000;

  localparam logic [DATA_W-1:0] UNLOCK_KEY_INIT = 32'h1688_A8A8;
  localparam logic [DATA_W-1:0] REV1_INIT       = 32'h0502_0303;
  localparam logic [DATA_W-1:0] REV2_INIT       = 32'h0000_0000;
  localparam logic [DATA_W-1:0] STRAP1_INIT     = 32'h0000_0000;
  localparam logic [DATA_W-1:0] STRAP2_INIT     = 32'h0000_0000;
  localparam logic [DATA_W-1:0] KEY_INIT        = 32'h0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNLOCK_KEY = 3'd0,
    CFG_REV1       = 3'd1,
    CFG_REV2       = 3'd2,
    CFG_STRAP1     = 3'd3,
    CFG_STRAP2     = 3'd4,
    CFG_KEY_INIT   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_RO     = 3'd2,
    ST_LOCKED = 3'd3,
    ST_PROT   = 3'd4
  } status_t;

  // named words served from flip-flops, constants or the input, not the memory
  typedef enum logic [3:0] {
    FW_NONE, FW_KEY, FW_REV1, FW_REV2, FW_RST1, FW_RST2, FW_CLK1, FW_CLK2,
    FW_HPLL, FW_STRAP1, FW_STRAP2, FW_RNG, FW_ID0, FW_ID1, FW_PROT1, FW_PROT2
  } fw_sel_t;

  typedef struct packed {
    fw_sel_t fw;       // flop word addressed directly
    fw_sel_t clr_tgt;  // word cleared through its alias, FW_NONE if not an alias
    logic    ro;
    logic    pll_ext;
  } word_class_t;

endpackage

`default_nettype wire

[rtl/core/scrf_decode.sv]
// ----------------------------------------------------------------------------
// scrf_decode
// Classify a word index: flop word, clear alias, read-only, PLL extension.
// ----------------------------------------------------------------------------
`default_nettype none

module scrf_decode (
  input  wire logic [scrf_pkg::IDX_W-1:0] word_index,
  output scrf_pkg::word_class_t           cls
);

  always_comb begin
    cls.fw      = scrf_pkg::FW_NONE;
    cls.clr_tgt = scrf_pkg::FW_NONE;
    cls.ro      = 1'b0;
    cls.pll_ext = 1'b0;
    case (word_index)
      scrf_pkg::W_KEY:          cls.fw = scrf_pkg::FW_KEY;
      scrf_pkg::W_REV1:   begin cls.fw = scrf_pkg::FW_REV1;   cls.ro = 1'b1; end
      scrf_pkg::W_REV2:   begin cls.fw = scrf_pkg::FW_REV2;   cls.ro = 1'b1; end
      scrf_pkg::W_RST1:         cls.fw = scrf_pkg::FW_RST1;
      scrf_pkg::W_RST2:         cls.fw = scrf_pkg::FW_RST2;
      scrf_pkg::W_CLK1:         cls.fw = scrf_pkg::FW_CLK1;
      scrf_pkg::W_CLK2:         cls.fw = scrf_pkg::FW_CLK2;
      scrf_pkg::W_HPLL:         cls.fw = scrf_pkg::FW_HPLL;
      scrf_pkg::W_STRAP1:       cls.fw = scrf_pkg::FW_STRAP1;
      scrf_pkg::W_STRAP2:       cls.fw = scrf_pkg::FW_STRAP2;
      scrf_pkg::W_PROT1:        cls.fw = scrf_pkg::FW_PROT1;
      scrf_pkg::W_PROT2:        cls.fw = scrf_pkg::FW_PROT2;
      scrf_pkg::W_RNG:    begin cls.fw = scrf_pkg::FW_RNG;    cls.ro = 1'b1; end
      scrf_pkg::W_ID0:    begin cls.fw = scrf_pkg::FW_ID0;    cls.ro = 1'b1; end
      scrf_pkg::W_ID1:    begin cls.fw = scrf_pkg::FW_ID1;    cls.ro = 1'b1; end
      scrf_pkg::W_RST1 + 10'd1:   cls.clr_tgt = scrf_pkg::FW_RST1;
      scrf_pkg::W_RST2 + 10'd1:   cls.clr_tgt = scrf_pkg::FW_RST2;
      scrf_pkg::W_CLK1 + 10'd1:   cls.clr_tgt = scrf_pkg::FW_CLK1;
      scrf_pkg::W_CLK2 + 10'd1:   cls.clr_tgt = scrf_pkg::FW_CLK2;
      scrf_pkg::W_STRAP1 + 10'd1: cls.clr_tgt = scrf_pkg::FW_STRAP1;
      scrf_pkg::W_STRAP2 + 10'd1: cls.clr_tgt = scrf_pkg::FW_STRAP2;
      scrf_pkg::W_HPLL_EXT,
      scrf_pkg::W_MPLL_EXT,
      scrf_pkg::W_EPLL_EXT:       cls.pll_ext = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/system_control_register_file.sv]
// ----------------------------------------------------------------------------
// system_control_register_file
// Word-addressed control register bank with key protection, set/clear
// aliases, strap protection and read-only identity words.
// ----------------------------------------------------------------------------
// One read or write word is accepted per cycle while s_tready is high; its
// result word passes through the memory read stage, then the output register.
// The named control words live in flip-flops; all other words sit in a
// REG_COUNT-deep single-port-write, registered-read memory. After reset a
// clearing pass zeroes the memory, one word per cycle; s_tready stays low
// throughout the pass, and configuration writes are taken during it.
// ----------------------------------------------------------------------------
`default_nettype none

module system_control_register_file #(
  parameter int unsigned REG_COUNT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // word_index[9:0], write_data[41:10], random_word[73:42]
  input  wire logic        s_tuser,   // func (0 read, 1 write)
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // read_data[31:0]
  output logic [2:0]       m_tuser,   // status[2:0]
  input  wire logic        cfg_we,
  input  wire logic [scrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned AW = $clog2(REG_COUNT);

  logic [scrf_pkg::IDX_W-1:0]  word_index;
  logic [scrf_pkg::DATA_W-1:0] write_data;
  logic [scrf_pkg::DATA_W-1:0] random_word;
  logic                        is_wr;

  assign word_index  = s_tdata[9:0];
  assign write_data  = s_tdata[41:10];
  assign random_word = s_tdata[73:42];
  assign is_wr       = s_tuser;

  scrf_pkg::word_class_t cls;

  scrf_decode u_decode (
    .word_index (word_index),
    .cls        (cls)
  );

  // flop words and live key
  logic [31:0] unlock_key;
  logic [31:0] key_word, rev1, rev2, rst1, rst2, clk1, clk2, hpll;
  logic [31:0] strap1, strap2, prot1, prot2;

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // memory
  logic [31:0] mem [REG_COUNT];
  logic [31:0] mem_q;

  // pipeline
  logic                 s1_valid;
  scrf_pkg::status_t    s1_status;
  logic [31:0]          s1_val;
  logic                 s1_use_mem;
  logic                 s1_pll;
  logic                 s1_adv;
  logic                 out_valid;
  logic [31:0]          out_data;
  scrf_pkg::status_t    out_status;

  logic                 acc;
  logic                 in_range;
  logic                 generic;
  logic                 protected_strap;
  logic                 apply;
  scrf_pkg::status_t    status_next;
  logic [31:0]          flop_rd;
  logic [31:0]          s1_val_next;
  logic                 use_mem_next;
  logic                 mem_re;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;

  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !clearing && (!s1_valid || !out_valid || m_tready);
  assign acc      = s_tvalid && s_tready;
  assign in_range = {1'b0, word_index} < (scrf_pkg::IDX_W + 1)'(REG_COUNT);
  assign generic  = (cls.fw == scrf_pkg::FW_NONE) && (cls.clr_tgt == scrf_pkg::FW_NONE);
  assign protected_strap = ((cls.fw == scrf_pkg::FW_STRAP1) && (prot1 != '0)) ||
                           ((cls.fw == scrf_pkg::FW_STRAP2) && (prot2 != '0));

  always_comb begin
    case (cls.fw)
      scrf_pkg::FW_KEY:    flop_rd = key_word;
      scrf_pkg::FW_REV1:   flop_rd = rev1;
      scrf_pkg::FW_REV2:   flop_rd = rev2;
      scrf_pkg::FW_RST1:   flop_rd = rst1;
      scrf_pkg::FW_RST2:   flop_rd = rst2;
      scrf_pkg::FW_CLK1:   flop_rd = clk1;
      scrf_pkg::FW_CLK2:   flop_rd = clk2;
      scrf_pkg::FW_HPLL:   flop_rd = hpll;
      scrf_pkg::FW_STRAP1: flop_rd = strap1;
      scrf_pkg::FW_STRAP2: flop_rd = strap2;
      scrf_pkg::FW_PROT1:  flop_rd = prot1;
      scrf_pkg::FW_PROT2:  flop_rd = prot2;
      scrf_pkg::FW_RNG:    flop_rd = random_word;
      scrf_pkg::FW_ID0:    flop_rd = scrf_pkg::ID0_VALUE;
      scrf_pkg::FW_ID1:    flop_rd = scrf_pkg::ID1_VALUE;
      default:             flop_rd = '0;
    endcase
  end

  always_comb begin
    status_next  = scrf_pkg::ST_OK;
    s1_val_next  = '0;
    use_mem_next = 1'b0;
    if (!in_range) begin
      status_next = scrf_pkg::ST_RANGE;
    end else if (!is_wr) begin
      s1_val_next  = flop_rd;
      use_mem_next = (cls.fw == scrf_pkg::FW_NONE);
    end else if (cls.fw == scrf_pkg::FW_KEY) begin
      status_next = scrf_pkg::ST_OK;
    end else if (cls.ro) begin
      status_next = scrf_pkg::ST_RO;
    end else if (protected_strap) begin
      status_next = scrf_pkg::ST_PROT;
    end else if (key_word == '0) begin
      status_next = scrf_pkg::ST_LOCKED;
    end
  end

  assign apply = acc && in_range && is_wr && (cls.fw != scrf_pkg::FW_KEY) && !cls.ro &&
                 !protected_strap;
  assign mem_re    = acc && use_mem_next;
  assign mem_we    = clearing || (apply && generic);
  assign mem_waddr = clearing ? clr_addr : word_index[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= clearing ? '0 : write_data;
    end
    if (mem_re) begin
      mem_q <= mem[word_index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(REG_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_key <= scrf_pkg::UNLOCK_KEY_INIT;
      key_word   <= scrf_pkg::KEY_INIT;
      rev1       <= scrf_pkg::REV1_INIT;
      rev2       <= scrf_pkg::REV2_INIT;
      rst1       <= scrf_pkg::RST1_INIT;
      rst2       <= scrf_pkg::RST2_INIT;
      clk1       <= scrf_pkg::CLK1_INIT;
      clk2       <= scrf_pkg::CLK2_INIT;
      hpll       <= scrf_pkg::HPLL_INIT;
      strap1     <= scrf_pkg::STRAP1_INIT;
      strap2     <= scrf_pkg::STRAP2_INIT;
      prot1      <= '0;
      prot2      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          scrf_pkg::CFG_UNLOCK_KEY: unlock_key <= cfg_data;
          scrf_pkg::CFG_REV1:       rev1       <= cfg_data;
          scrf_pkg::CFG_REV2:       rev2       <= cfg_data;
          scrf_pkg::CFG_STRAP1:     strap1     <= cfg_data;
          scrf_pkg::CFG_STRAP2:     strap2     <= cfg_data;
          scrf_pkg::CFG_KEY_INIT:   key_word   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (acc && in_range && is_wr && (cls.fw == scrf_pkg::FW_KEY)) begin
        key_word <= {31'd0, write_data == unlock_key};
      end
      if (apply) begin
        case (cls.fw)
          scrf_pkg::FW_RST1:   rst1   <= rst1 | write_data;
          scrf_pkg::FW_RST2:   rst2   <= rst2 | write_data;
          scrf_pkg::FW_CLK1:   clk1   <= clk1 | write_data;
          scrf_pkg::FW_CLK2:   clk2   <= clk2 | write_data;
          scrf_pkg::FW_STRAP1: strap1 <= strap1 | write_data;
          scrf_pkg::FW_STRAP2: strap2 <= strap2 | write_data;
          scrf_pkg::FW_HPLL:   hpll   <= write_data;
          scrf_pkg::FW_PROT1:  prot1  <= write_data;
          scrf_pkg::FW_PROT2:  prot2  <= write_data;
          default: begin
          end
        endcase
        case (cls.clr_tgt)
          scrf_pkg::FW_RST1:   rst1   <= rst1 & ~write_data;
          scrf_pkg::FW_RST2:   rst2   <= rst2 & ~write_data;
          scrf_pkg::FW_CLK1:   clk1   <= clk1 & ~write_data;
          scrf_pkg::FW_CLK2:   clk2   <= clk2 & ~write_data;
          scrf_pkg::FW_STRAP1: strap1 <= strap1 & ~write_data;
          scrf_pkg::FW_STRAP2: strap2 <= strap2 & ~write_data;
          default: begin
          end
        endcase
      end
    end
  end

  // result pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_status  <= status_next;
      s1_val     <= s1_val_next;
      s1_use_mem <= use_mem_next;
      s1_pll     <= cls.pll_ext;
    end
    if (s1_adv) begin
      out_status <= s1_status;
      out_data   <= s1_use_mem ? (mem_q | (s1_pll ? scrf_pkg::PLL_LOCK : '0)) : s1_val;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_status;

  a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("word accepted during memory clearing pass");

  a_read_status_ok : assert property (@(posedge clk) disable iff (rst)
    (acc && !is_wr && in_range) |=> (s1_status == scrf_pkg::ST_OK))
    else $error("in-range read produced non-ok status");

  a_key_write : assert property (@(posedge clk) disable iff (rst)
    (acc && is_wr && in_range && (cls.fw == scrf_pkg::FW_KEY)) |=>
      (key_word == {31'd0, $past(write_data) == $past(unlock_key)}))
    else $error("key word not updated from unlock compare");

endmodule

`default_nettype wire

[dv/system_control_register_file_tb.sv]
// ----------------------------------------------------------------------------
// system_control_register_file_tb
// Streams word reads and writes into the register file and checks every
// result word against a cycle-free model of the word map: key unlock, set
// and clear aliases, strap protection, read-only words, PLL lock bits and
// the random word. Several configuration settings are applied between
// phases, and both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module system_control_register_file_tb;
  import scrf_pkg::*;

  localparam int unsigned REG_COUNT   = 1024;
  localparam int          RANDOM_WORDS = 225;
  localparam int          PHASES       = 5;
  localparam int          STALL_LIMIT  = 8000;

  typedef enum bit {ACC_READ = 1'b0, ACC_WRITE = 1'b1} access_kind_t;

  typedef struct {
    access_kind_t kind;
    logic [9:0]   idx;
    logic [31:0]  wdata;
    logic [31:0]  rnd;
  } access_t;

  typedef struct {
    logic [31:0] data;
    status_t     st;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  access_t     access_queue[$];
  reply_t      expected_replies[$];
  access_t     driven_word;
  logic [31:0] regs [0:1023];
  logic [31:0] unlock_key_cfg;
  logic [9:0]  hot_words[$];
  bit          in_taken;
  bit          out_taken;
  bit          failed;
  int          idle_cycles;
  int          burst_left;
  int          gap_left;
  int          rx_tick;
  int          rx_mode;

  system_control_register_file #(.REG_COUNT(REG_COUNT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_access(input access_t a, output reply_t r);
    logic locked;
    r.data = '0;
    r.st = ST_OK;
    if (a.idx >= REG_COUNT) begin
      r.st = ST_RANGE;
    end else if (a.kind == ACC_READ) begin
      if (a.idx == W_HPLL_EXT || a.idx == W_MPLL_EXT || a.idx == W_EPLL_EXT) begin
        r.data = regs[a.idx] | 32'h8000_0000;
      end else begin
        if (a.idx == W_RNG) regs[a.idx] = a.rnd;
        r.data = regs[a.idx];
      end
    end else if (a.idx == W_KEY) begin
      regs[W_KEY] = (a.wdata == unlock_key_cfg) ? 32'd1 : 32'd0;
    end else begin
      locked = (regs[W_KEY] == 32'd0);
      case (a.idx)
        W_REV1, W_REV2, W_RNG, W_ID0, W_ID1: r.st = ST_RO;
        W_STRAP1, W_STRAP2: begin
          if (regs[a.idx + 10'd2] != 32'd0) r.st = ST_PROT;
          else regs[a.idx] |= a.wdata;
        end
        W_RST1, W_RST2, W_CLK1, W_CLK2: regs[a.idx] |= a.wdata;
        W_RST1 + 10'd1, W_RST2 + 10'd1, W_CLK1 + 10'd1, W_CLK2 + 10'd1,
        W_STRAP1 + 10'd1, W_STRAP2 + 10'd1: regs[a.idx - 10'd1] &= ~a.wdata;
        default: regs[a.idx] = a.wdata;
      endcase
      if (locked && r.st == ST_OK) r.st = ST_LOCKED;
    end
  endtask

  task automatic push_access(input access_kind_t kind, input logic [9:0] idx,
                             input logic [31:0] wdata, input logic [31:0] rnd);
    access_t a;
    a.kind = kind;
    a.idx = idx;
    a.wdata = wdata;
    a.rnd = rnd;
    access_queue.push_back(a);
  endtask

  task automatic apply_setting(input cfg_idx_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_UNLOCK_KEY: unlock_key_cfg = v;
      CFG_REV1:       regs[W_REV1] = v;
      CFG_REV2:       regs[W_REV2] = v;
      CFG_STRAP1:     regs[W_STRAP1] = v;
      CFG_STRAP2:     regs[W_STRAP2] = v;
      CFG_KEY_INIT:   regs[W_KEY] = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (access_queue.size() != 0 || s_tvalid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sender: bursts of random length, random gaps between them
  always @(negedge clk) begin
    access_t a;
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else if (!s_tvalid || in_taken) begin
      if (gap_left != 0 || access_queue.size() == 0) begin
        if (gap_left != 0) gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        a = access_queue.pop_front();
        driven_word = a;
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, a.rnd, a.wdata, a.idx};
        s_tuser <= a.kind;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: stall pattern switches among four modes, picked at random
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 256 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= (rx_tick % 9) >= 4;
      default: m_tready <= (rx_tick % 23) < 3;
    endcase
  end

  always @(posedge clk) begin
    reply_t want;
    in_taken = s_tvalid && s_tready;
    out_taken = m_tvalid && m_tready;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
      if (in_taken) begin
        predict_access(driven_word, want);
        expected_replies.push_back(want);
      end
      if (out_taken) begin
        if (expected_replies.size() == 0) begin
          $error("result word with none expected: read_data %h status %0d", m_tdata, m_tuser);
          failed = 1'b1;
        end else begin
          want = expected_replies.pop_front();
          if (m_tdata !== want.data) begin
            $error("read_data expected %h got %h", want.data, m_tdata);
            failed = 1'b1;
          end
          if (m_tuser !== want.st) begin
            $error("status expected %0d got %0d", want.st, m_tuser);
            failed = 1'b1;
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("system_control_register_file_tb: FAIL");
    $finish;
  end

  initial begin
    logic [31:0]  v;
    logic [31:0]  d;
    logic [9:0]   idx;
    access_kind_t kind;
    int           pick;
    rx_mode = 0;
    rx_tick = 0;
    failed = 1'b0;
    idle_cycles = 0;
    hot_words = '{W_KEY, W_REV1, W_REV2, W_RST1, W_RST1 + 10'd1, W_RST2, W_RST2 + 10'd1,
                  W_CLK1, W_CLK1 + 10'd1, W_CLK2, W_CLK2 + 10'd1, W_HPLL, W_HPLL_EXT,
                  W_MPLL_EXT, W_EPLL_EXT, W_STRAP1, W_STRAP1 + 10'd1, W_PROT1,
                  W_STRAP2, W_STRAP2 + 10'd1, W_PROT2, W_RNG, W_ID0, W_ID1};
    for (int i = 0; i < 1024; i++) regs[i] = '0;
    regs[W_RST1] = 32'hF7C3_FED8;
    regs[W_RST2] = 32'hFFFF_FFFC;
    regs[W_CLK1] = 32'hFFFF_7F8A;
    regs[W_CLK2] = 32'hFFF0_FFF0;
    regs[W_HPLL] = 32'h1000_405F;
    regs[W_ID0]  = 32'h1234_ABCD;
    regs[W_ID1]  = 32'h8888_4444;
    regs[W_REV1] = 32'h0502_0303;
    unlock_key_cfg = 32'h1688_A8A8;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_access(ACC_READ,  W_KEY,      '0, '0);
    push_access(ACC_READ,  W_REV1,     '0, '0);
    push_access(ACC_WRITE, W_RST1,     32'hFFFF_FFFF, '0);
    push_access(ACC_READ,  W_RST1,     '0, '0);
    push_access(ACC_WRITE, W_KEY,      32'h0, '0);
    push_access(ACC_WRITE, W_KEY,      unlock_key_cfg, '0);
    push_access(ACC_READ,  W_KEY,      '0, '0);
    push_access(ACC_WRITE, W_RST1 + 10'd1, 32'hFFFF_FFFF, '0);
    push_access(ACC_READ,  W_RST1,     '0, 32'hFFFF_FFFF);
    push_access(ACC_WRITE, W_REV1,     32'hFFFF_FFFF, '0);
    push_access(ACC_WRITE, W_PROT1,    32'h1, '0);
    push_access(ACC_WRITE, W_STRAP1,   32'hFFFF_FFFF, '0);
    push_access(ACC_WRITE, W_PROT1,    32'h0, '0);
    push_access(ACC_WRITE, W_STRAP1,   32'hA5A5_A5A5, '0);
    push_access(ACC_WRITE, W_STRAP1 + 10'd1, 32'h0000_FFFF, '0);
    push_access(ACC_READ,  W_STRAP1,   '0, '0);
    push_access(ACC_WRITE, W_HPLL_EXT, 32'h1234_5678, '0);
    push_access(ACC_READ,  W_HPLL_EXT, '0, '0);
    push_access(ACC_READ,  W_MPLL_EXT, '0, '0);
    push_access(ACC_READ,  W_RNG,      '0, 32'hDEAD_BEEF);
    push_access(ACC_WRITE, W_RNG,      32'h0, '0);
    push_access(ACC_READ,  W_RNG,      '0, 32'h0);
    push_access(ACC_WRITE, 10'h3FE,    32'hFFFF_FFFF, '0);
    push_access(ACC_READ,  10'h3FF,    '0, '0);
    push_access(ACC_WRITE, 10'h003,    32'hFFFF_FFFF, '0);
    push_access(ACC_READ,  10'h003,    '0, '0);
    push_access(ACC_READ,  W_ID1,      '0, '0);
    drain();

    for (int phase = 1; phase <= PHASES; phase++) begin
      for (int r = 0; r < 6; r++) begin
        case (phase)
          1: v = '0;
          2: v = '1;
          default: v = $urandom;
        endcase
        if (r == CFG_KEY_INIT && phase > 2 && $urandom_range(0, 1) == 0) v = '0;
        apply_setting(cfg_idx_t'(r), v);
      end
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        kind = access_kind_t'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0, 1: d = '0;
          2: d = '1;
          3: d = 32'h1 << $urandom_range(0, 31);
          default: d = $urandom;
        endcase
        if (pick < 8) begin
          kind = ACC_WRITE;
          idx = W_KEY;
          if ($urandom_range(0, 2) != 0) d = unlock_key_cfg;
        end else if (pick < 55) begin
          idx = hot_words[$urandom_range(0, hot_words.size() - 1)];
        end else if (pick < 80) begin
          idx = 10'($urandom_range(0, 63));
        end else begin
          idx = 10'($urandom_range(0, 1023));
        end
        push_access(kind, idx, d, $urandom);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("system_control_register_file_tb: PASS");
    end else begin
      $display("system_control_register_file_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/core/scrf_pkg.sv
rtl/core/scrf_decode.sv
rtl/core/system_control_register_file.sv
dv/system_control_register_file_tb.sv
